### sv/nptm_pkg.sv
package nptm_pkg;

  localparam int MAX_TARGETS_DEF = 1024;

  // coordinate and result field widths
  localparam int COORD_W = 16;
  localparam int KIND_W  = 2;
  localparam int QNUM_W  = 16;
  localparam int BIDX_W  = 10;
  localparam int DIST_W  = 33;
  localparam int GATE_W  = 16;

  // |a - b| needs one bit more than a coordinate, its square twice that
  localparam int ADIFF_W = COORD_W + 1;
  localparam int SQ_W    = 2 * ADIFF_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int GSQ_W   = 2 * GATE_W;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_LOAD  = 2'd0;
  localparam kind_t KIND_QUERY = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic load;   // append the input point to the target set
    logic clear;  // empty the set, restart query numbering
    logic start;  // latch the query point and reset the running best
    logic issue;  // read the next target and push it into the pipeline
    logic emit;   // write the result register, advance query number
  } nptm_cmd_t;

  typedef struct packed {
    logic count_zero;  // no target stored
    logic last_addr;   // scan address is the last stored target
    logic pipe_busy;   // distance pipeline still holds a target
    logic out_free;    // result register can take a result this cycle
  } nptm_status_t;

endpackage

### sv/nptm_in_if.sv
interface nptm_in_if;
  import nptm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic signed [COORD_W-1:0]  point_x;
  logic signed [COORD_W-1:0]  point_y;

  modport source (output valid, output kind, output point_x, output point_y, input ready);
  modport sink   (input valid, input kind, input point_x, input point_y, output ready);
endinterface

### sv/nptm_out_if.sv
interface nptm_out_if;
  import nptm_pkg::*;

  logic               valid;
  logic               ready;
  logic [QNUM_W-1:0]  query_number;
  logic               match_found;
  logic [BIDX_W-1:0]  best_index;
  logic [DIST_W-1:0]  distance_sq;
  logic               within_gate;

  modport source (output valid, output query_number, output match_found,
                  output best_index, output distance_sq, output within_gate,
                  input ready);
  modport sink   (input valid, input query_number, input match_found,
                  input best_index, input distance_sq, input within_gate,
                  output ready);
endinterface

### sv/nptm_ctrl.sv
module nptm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [nptm_pkg::KIND_W-1:0] in_kind,
  output logic                   in_ready,
  output nptm_pkg::nptm_cmd_t    cmd,
  input  nptm_pkg::nptm_status_t status
);
  import nptm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = (in_kind == KIND_LOAD);
          cmd.clear = (in_kind == KIND_CLEAR);
          if (in_kind == KIND_QUERY) begin
            cmd.start = 1'b1;
            state_nxt = status.count_zero ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.last_addr) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold the finished query until the result register frees up
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

`ifndef SYNTHESIS
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !status.count_zero)
    else $error("scan running on an empty target set");

  a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && status.last_addr) |=> (state_r == ST_DRAIN))
    else $error("scan did not stop after the last target");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state is not one-hot");
`endif

endmodule

### sv/nptm_dpath.sv
module nptm_dpath #(
  parameter int MAX_TARGETS = nptm_pkg::MAX_TARGETS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  nptm_pkg::nptm_cmd_t            cmd,
  output nptm_pkg::nptm_status_t         status,
  input  logic signed [nptm_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [nptm_pkg::COORD_W-1:0] in_point_y,
  input  logic                           cfg_we,
  input  logic [nptm_pkg::GATE_W-1:0]    cfg_wdata,
  nptm_out_if.source                     out_ch
);
  import nptm_pkg::*;

  localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int BX_W  = (IDX_W > BIDX_W) ? IDX_W : BIDX_W;

  logic signed [COORD_W-1:0] mem_x [MAX_TARGETS];
  logic signed [COORD_W-1:0] mem_y [MAX_TARGETS];

  logic [CNT_W-1:0]  count_r;
  logic [QNUM_W-1:0] qcnt_r;
  logic [GATE_W-1:0] gate_r;
  logic [GSQ_W-1:0]  gate_sq_r;

  logic signed [COORD_W-1:0] qx_r, qy_r;
  logic [IDX_W-1:0]          addr_r;

  // pipeline: read, abs difference, square, accumulate
  logic                      v1_r, v2_r, v3_r;
  logic [IDX_W-1:0]          idx1_r, idx2_r, idx3_r;
  logic signed [COORD_W-1:0] tx_r, ty_r;
  logic [ADIFF_W-1:0]        dx_r, dy_r;
  logic [SQ_W-1:0]           sx_r, sy_r;

  logic                      found_r;
  logic [SUM_W-1:0]          best_r;
  logic [IDX_W-1:0]          best_idx_r;

  logic signed [ADIFF_W-1:0] diff_x, diff_y;
  logic [SUM_W-1:0]          dsum;
  logic                      take;
  logic                      full;
  logic [BX_W-1:0]           best_idx_ext;

  logic               out_valid_r;
  logic [QNUM_W-1:0]  out_qnum_r;
  logic               out_found_r;
  logic [BIDX_W-1:0]  out_idx_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic               out_gate_r;

  assign full = (count_r == CNT_W'(MAX_TARGETS));

  assign status.count_zero = (count_r == '0);
  assign status.last_addr  = (({1'b0, addr_r} + CNT_W'(1)) == count_r);
  assign status.pipe_busy  = v1_r || v2_r || v3_r;
  assign status.out_free   = !out_valid_r || out_ch.ready;

  // target store
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem_x[count_r[IDX_W-1:0]] <= in_point_x;
      mem_y[count_r[IDX_W-1:0]] <= in_point_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      tx_r <= mem_x[addr_r];
      ty_r <= mem_y[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      qcnt_r  <= '0;
      gate_r  <= '1;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
        qcnt_r  <= '0;
      end else if (cmd.load && !full) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.emit) qcnt_r <= qcnt_r + QNUM_W'(1);
      if (cfg_we)   gate_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    gate_sq_r <= GSQ_W'(gate_r) * GSQ_W'(gate_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx_r   <= in_point_x;
      qy_r   <= in_point_y;
      addr_r <= '0;
    end else if (cmd.issue) begin
      addr_r <= addr_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign diff_x = ADIFF_W'(qx_r) - ADIFF_W'(tx_r);
  assign diff_y = ADIFF_W'(qy_r) - ADIFF_W'(ty_r);

  always_ff @(posedge clk) begin
    idx1_r <= addr_r;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    dx_r   <= diff_x[ADIFF_W-1] ? ADIFF_W'(-diff_x) : ADIFF_W'(diff_x);
    dy_r   <= diff_y[ADIFF_W-1] ? ADIFF_W'(-diff_y) : ADIFF_W'(diff_y);
    sx_r   <= SQ_W'(dx_r) * SQ_W'(dx_r);
    sy_r   <= SQ_W'(dy_r) * SQ_W'(dy_r);
  end

  assign dsum = SUM_W'(sx_r) + SUM_W'(sy_r);
  // strict compare keeps the lowest index on a tie
  assign take = v3_r && (!found_r || (dsum < best_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.start) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_r     <= dsum;
      best_idx_r <= idx3_r;
    end
  end

  assign best_idx_ext = BX_W'(best_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_qnum_r  <= qcnt_r;
      out_found_r <= found_r;
      out_idx_r   <= found_r ? best_idx_ext[BIDX_W-1:0] : '0;
      out_dist_r  <= found_r ? best_r[DIST_W-1:0] : '0;
      out_gate_r  <= found_r && (best_r <= SUM_W'(gate_sq_r));
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.query_number = out_qnum_r;
  assign out_ch.match_found  = out_found_r;
  assign out_ch.best_index   = out_idx_r;
  assign out_ch.distance_sq  = out_dist_r;
  assign out_ch.within_gate  = out_gate_r;

`ifndef SYNTHESIS
  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> ({1'b0, addr_r} < count_r))
    else $error("scan read past the stored targets");

  a_emit_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(v1_r || v2_r || v3_r))
    else $error("result written while distances still in flight");

  a_clear_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (qcnt_r == '0 && count_r == '0))
    else $error("clear did not restart the set and numbering");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TARGETS))
    else $error("target count above capacity");
`endif

endmodule

### sv/nearest_point_matcher_gated.sv
// Brute-force 2-D nearest point matcher with a distance gate. Load items append
// a target point (ignored once MAX_TARGETS are held), clear items empty the set
// and restart query numbering; neither gives a result nor leaves IDLE. A query
// scans the stored targets in index order, one squared distance per cycle out of
// the single read port of the target memory, through a three-stage
// abs-difference / square / compare pipeline. A query holds the input while it
// scans and drains the pipeline (an empty set skips both), and while its result
// waits for the previous one to be taken from the output register.
// Loads and clears are still taken while a finished result waits at the output.
// gate_radius is written through cfg_we/cfg_wdata and compared squared.
module nearest_point_matcher_gated #(
  parameter int MAX_TARGETS = nptm_pkg::MAX_TARGETS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  nptm_in_if.sink                     in_ch,
  nptm_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [nptm_pkg::GATE_W-1:0] cfg_wdata
);
  import nptm_pkg::*;

  nptm_cmd_t    cmd;
  nptm_status_t status;

  nptm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .status   (status)
  );

  nptm_dpath #(
    .MAX_TARGETS (MAX_TARGETS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_point_x (in_ch.point_x),
    .in_point_y (in_ch.point_y),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_ch     (out_ch)
  );

endmodule

### dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nptm_pkg::*;

  localparam kind_t KIND_UNUSED = 2'd3;

  localparam int IDLE_PCT      = 21;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 20000;
  localparam int RANDOM_ITEMS  = 560;

  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
  localparam logic [GATE_W-1:0]         GATE_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [QNUM_W-1:0] query_number;
    logic              match_found;
    logic [BIDX_W-1:0] best_index;
    logic [DIST_W-1:0] distance_sq;
    logic              within_gate;
  } match_result_t;

  class nearest_match_tracker;
    logic signed [COORD_W-1:0] target_x [MAX_TARGETS_DEF];
    logic signed [COORD_W-1:0] target_y [MAX_TARGETS_DEF];
    int unsigned               target_count;
    logic [QNUM_W-1:0]         query_count;
    logic [GATE_W-1:0]         gate_radius;
    match_result_t             awaited_matches [$];
    int unsigned               errors;

    function new();
      target_count = 0;
      query_count  = '0;
      gate_radius  = GATE_MAX;
      errors       = 0;
    endfunction

    // update the target set for one accepted transfer, queue the match of a query
    function void take_item(kind_t kind, logic signed [COORD_W-1:0] px,
                            logic signed [COORD_W-1:0] py);
      match_result_t     m;
      longint            dx;
      longint            dy;
      longint unsigned   d;
      longint unsigned   best;
      longint unsigned   gate_wide;
      case (kind)
        KIND_LOAD: begin
          if (target_count < MAX_TARGETS_DEF) begin
            target_x[target_count] = px;
            target_y[target_count] = py;
            target_count++;
          end
        end
        KIND_CLEAR: begin
          target_count = 0;
          query_count  = '0;
        end
        KIND_QUERY: begin
          m = '0;
          best = '1;
          m.query_number = query_count;
          for (int i = 0; i < target_count; i++) begin
            dx = px - target_x[i];
            dy = py - target_y[i];
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            d = dx * dx + dy * dy;
            // strict compare keeps the lowest index on a tie
            if (!m.match_found || d < best) begin
              best = d;
              m.best_index = i[BIDX_W-1:0];
              m.match_found = 1'b1;
            end
          end
          if (m.match_found) begin
            gate_wide = gate_radius;
            m.distance_sq = best[DIST_W-1:0];
            m.within_gate = (best <= gate_wide * gate_wide);
          end
          awaited_matches.insert(awaited_matches.size(), m);
          query_count++;
        end
        default: ;
      endcase
    endfunction

    function void report(string field, longint unsigned exp_v, longint unsigned act_v);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
      errors++;
    endfunction

    function void compare_match(match_result_t got);
      match_result_t want;
      if (awaited_matches.size() == 0) begin
        $display("%0t: result with no query outstanding, query_number %0d", $time,
                 got.query_number);
        errors++;
        return;
      end
      want = awaited_matches.pop_front();
      if (got.query_number !== want.query_number)
        report("query_number", want.query_number, got.query_number);
      if (got.match_found !== want.match_found)
        report("match_found", want.match_found, got.match_found);
      if (got.best_index !== want.best_index)
        report("best_index", want.best_index, got.best_index);
      if (got.distance_sq !== want.distance_sq)
        report("distance_sq", want.distance_sq, got.distance_sq);
      if (got.within_gate !== want.within_gate)
        report("within_gate", want.within_gate, got.within_gate);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [GATE_W-1:0] cfg_wdata;

  nptm_in_if  in_ch ();
  nptm_out_if out_ch ();

  nearest_point_matcher_gated DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  nearest_match_tracker tracker = new();

  bit          steady    = 1'b0;
  bit          stall_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // transfer monitors
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      tracker.take_item(in_ch.kind, in_ch.point_x, in_ch.point_y);
  end

  always @(posedge clk) begin : result_monitor
    match_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.query_number, out_ch.match_found, out_ch.best_index,
             out_ch.distance_sq, out_ch.within_gate};
      tracker.compare_match(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("nearest_point_matcher_gated verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random back-pressure, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_req = 1'b0;
      end
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic signed [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom);
  endfunction

  function automatic logic signed [COORD_W-1:0] jitter(logic signed [COORD_W-1:0] c,
                                                       int radius);
    int offset;
    offset = int'($urandom_range(2 * radius)) - radius;
    return c + offset[COORD_W-1:0];
  endfunction

  task automatic send_item(input kind_t kind, input logic signed [COORD_W-1:0] px,
                           input logic signed [COORD_W-1:0] py);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    items_sent++;
  endtask

  // loads leave no result behind, so let the block settle after the last one
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gate(input logic [GATE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.gate_radius = value;
  endtask

  // clustered targets, queries mostly near one of them, some noise mixed in
  task automatic run_round(input int n_targets, input int n_queries, input int spread);
    logic signed [COORD_W-1:0] base_x;
    logic signed [COORD_W-1:0] base_y;
    logic signed [COORD_W-1:0] loaded_x [$];
    logic signed [COORD_W-1:0] loaded_y [$];
    int                        pick;
    base_x = rand_coord();
    base_y = rand_coord();
    if ($urandom_range(4) != 0)
      send_item(KIND_CLEAR, rand_coord(), rand_coord());
    for (int i = 0; i < n_targets; i++) begin
      loaded_x.insert(loaded_x.size(), jitter(base_x, 4 * spread));
      loaded_y.insert(loaded_y.size(), jitter(base_y, 4 * spread));
      send_item(KIND_LOAD, loaded_x[i], loaded_y[i]);
    end
    for (int i = 0; i < n_queries; i++) begin
      if (n_targets != 0 && $urandom_range(9) < 8) begin
        pick = $urandom_range(n_targets - 1);
        send_item(KIND_QUERY, jitter(loaded_x[pick], spread), jitter(loaded_y[pick], spread));
      end else begin
        send_item(KIND_QUERY, rand_coord(), rand_coord());
      end
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0:       send_item(KIND_UNUSED, rand_coord(), rand_coord());
          1:       send_item(KIND_LOAD, rand_coord(), rand_coord());
          default: send_item(KIND_QUERY, rand_coord(), rand_coord());
        endcase
      end
    end
  endtask

  initial begin
    int unsigned               random_start;
    int                        round;
    int                        spread;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= KIND_LOAD;
    in_ch.point_x <= '0;
    in_ch.point_y <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty set, unused kind, extreme corners, ties, exact hits
    send_item(KIND_QUERY, 16'sd0, 16'sd0);
    send_item(KIND_UNUSED, 16'sd1234, -16'sd1234);
    send_item(KIND_LOAD, COORD_MIN, COORD_MIN);
    send_item(KIND_QUERY, COORD_MAX, COORD_MAX);
    send_item(KIND_LOAD, COORD_MAX, COORD_MAX);
    send_item(KIND_LOAD, 16'sd0, 16'sd0);
    send_item(KIND_LOAD, 16'sd0, 16'sd0);
    send_item(KIND_LOAD, 16'sd100, 16'sd0);
    send_item(KIND_LOAD, 16'sd0, 16'sd100);
    send_item(KIND_QUERY, 16'sd50, 16'sd50);
    send_item(KIND_QUERY, 16'sd0, 16'sd0);
    send_item(KIND_QUERY, COORD_MIN, COORD_MAX);
    send_item(KIND_CLEAR, COORD_MAX, COORD_MIN);
    send_item(KIND_QUERY, 16'sd5, 16'sd5);
    send_item(KIND_LOAD, 16'sd1, -16'sd1);
    send_item(KIND_QUERY, -16'sd1, 16'sd1);

    // gate of zero, then a distance right on the gate
    wait_idle();
    write_gate('0);
    send_item(KIND_QUERY, 16'sd1, -16'sd1);
    send_item(KIND_QUERY, 16'sd2, -16'sd1);
    wait_idle();
    write_gate(16'd3);
    send_item(KIND_QUERY, 16'sd4, -16'sd1);
    send_item(KIND_QUERY, 16'sd4, 16'sd0);

    random_start = items_sent;
    round = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      steady = (round >= 4 && round < 8);
      spread = ($urandom_range(1) != 0) ? $urandom_range(1, 40) : $urandom_range(41, 3000);
      if ($urandom_range(1) == 0) begin
        wait_idle();
        case ($urandom_range(4))
          0:       write_gate('0);
          1:       write_gate(GATE_MAX);
          2:       write_gate(GATE_W'($urandom));
          default: write_gate(GATE_W'($urandom_range(2 * spread)));
        endcase
      end
      if (round == 10) begin
        // receiver holds off while queries keep coming
        stall_req = 1'b1;
        run_round(8, 30, spread);
      end else begin
        run_round(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24),
                  $urandom_range(1, 8), spread);
      end
      round++;
    end
    steady = 1'b0;

    wait_idle();
    if (tracker.errors == 0 && tracker.awaited_matches.size() == 0) begin
      $display("nearest_point_matcher_gated verification clean");
    end else begin
      $display("nearest_point_matcher_gated verification failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/nptm_pkg.sv
sv/nptm_in_if.sv
sv/nptm_out_if.sv
sv/nptm_ctrl.sv
sv/nptm_dpath.sv
sv/nearest_point_matcher_gated.sv
dv/testbench.sv
